@@ src/cdr_pkg.sv @@
// Shared constants for the CAN diagnostic responder: identifiers, service codes and widths.
`timescale 1ns / 1ps

package cdr_pkg;

  // Field widths.
  localparam int FrameIdW = 11;
  localparam int ByteW    = 8;
  localparam int RespIdW  = 12;
  localparam int WordW    = 32;
  localparam int BusIdW   = 16;
  localparam int PidW     = 16;

  // Frame identifiers.
  localparam logic [FrameIdW-1:0] FuncId   = 11'h7DF;
  localparam logic [RespIdW-1:0]  RespBase = 12'h780;

  // Service identifiers and response codes.
  localparam logic [ByteW-1:0] SvcSession  = 8'h10;
  localparam logic [ByteW-1:0] SvcRead     = 8'h22;
  localparam logic [ByteW-1:0] SvcWrite    = 8'h2E;
  localparam logic [ByteW-1:0] PosOffset   = 8'h40;
  localparam logic [ByteW-1:0] NegSid      = 8'h7F;
  localparam logic [ByteW-1:0] NrcFormat   = 8'h13;
  localparam logic [ByteW-1:0] NrcSubfunc  = 8'h12;
  localparam logic [ByteW-1:0] NrcService  = 8'h11;

  // Session subfunctions.
  localparam logic [ByteW-1:0] SubLeave    = 8'h00;
  localparam logic [ByteW-1:0] SubOpen     = 8'h02;
  localparam logic [ByteW-1:0] SubOpenSer  = 8'h05;

  // Response lengths.
  localparam logic [ByteW-1:0] LenShort    = 8'd3;
  localparam logic [ByteW-1:0] LenByte     = 8'd4;
  localparam logic [ByteW-1:0] LenHalf     = 8'd5;
  localparam logic [ByteW-1:0] LenWord     = 8'd7;

  // Parameter identifiers.
  typedef enum logic [2:0] {
    PID_NONE   = 3'd0,
    PID_SERIAL = 3'd1,
    PID_NODE   = 3'd2,
    PID_GAIN_P = 3'd3,
    PID_GAIN_I = 3'd4,
    PID_GAIN_D = 3'd5,
    PID_LIMIT  = 3'd6,
    PID_BUS_ID = 3'd7
  } pid_t;

endpackage

@@ src/can_diagnostic_responder.sv @@
// A response item is registered at the clock edge that accepts its request item.
// Throughput: one request item per cycle; the only stall is a held response register.
// Requests that need no answer leave the state as it is and produce no response item.
// Reset (synchronous, active high) clears the session flag, all parameters and the
// result valid (not resp_valid); parameters are then loaded by write requests.
`timescale 1ns / 1ps

module can_diagnostic_responder
  import cdr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_valid,
  output logic                frame_ready,
  input  logic [FrameIdW-1:0] frame_id,
  input  logic [ByteW-1:0]    req_byte_0,
  input  logic [ByteW-1:0]    req_byte_1,
  input  logic [ByteW-1:0]    req_byte_2,
  input  logic [ByteW-1:0]    req_byte_3,
  input  logic [ByteW-1:0]    req_byte_4,
  input  logic [ByteW-1:0]    req_byte_5,
  input  logic [ByteW-1:0]    req_byte_6,
  input  logic [ByteW-1:0]    req_byte_7,
  output logic                result_valid,
  input  logic                result_ready,
  output logic                resp_valid,
  output logic [RespIdW-1:0]  resp_id,
  output logic [ByteW-1:0]    resp_byte_0,
  output logic [ByteW-1:0]    resp_byte_1,
  output logic [ByteW-1:0]    resp_byte_2,
  output logic [ByteW-1:0]    resp_byte_3,
  output logic [ByteW-1:0]    resp_byte_4,
  output logic [ByteW-1:0]    resp_byte_5,
  output logic [ByteW-1:0]    resp_byte_6,
  output logic [ByteW-1:0]    resp_byte_7,
  output logic                save_request
);

  // Device state.
  logic              session_open, session_open_next;
  logic [WordW-1:0]  serial_number, serial_number_next;
  logic [ByteW-1:0]  node_id, node_id_next;
  logic [WordW-1:0]  gain_p_bits, gain_p_bits_next;
  logic [WordW-1:0]  gain_i_bits, gain_i_bits_next;
  logic [WordW-1:0]  gain_d_bits, gain_d_bits_next;
  logic [WordW-1:0]  drive_limit_bits, drive_limit_bits_next;
  logic [BusIdW-1:0] bus_id_param, bus_id_param_next;

  // Decoded request fields.
  logic              accept;
  logic              functional;
  logic [PidW-1:0]   pid;
  logic [WordW-1:0]  value;
  logic              pid_ok;
  pid_t              pid_sel;

  // Response being built.
  logic              emit;
  logic              save;
  logic [ByteW-1:0]  len;
  logic [ByteW-1:0]  b1;
  logic [ByteW-1:0]  b2;
  logic [ByteW-1:0]  b3;
  logic [WordW-1:0]  val;

  assign frame_ready = !result_valid || result_ready;
  assign accept      = frame_valid && frame_ready;
  assign functional  = (frame_id == FuncId);
  assign pid         = {req_byte_2, req_byte_3};
  assign value       = {req_byte_7, req_byte_6, req_byte_5, req_byte_4};
  assign pid_ok      = (pid[PidW-1:3] == '0) && (pid[2:0] != 3'd0);
  assign pid_sel     = pid_t'(pid[2:0]);

  // Request decode, state update and response contents.
  always_comb begin
    session_open_next     = session_open;
    serial_number_next    = serial_number;
    node_id_next          = node_id;
    gain_p_bits_next      = gain_p_bits;
    gain_i_bits_next      = gain_i_bits;
    gain_d_bits_next      = gain_d_bits;
    drive_limit_bits_next = drive_limit_bits;
    bus_id_param_next     = bus_id_param;
    emit = 1'b0;
    save = 1'b0;
    len  = '0;
    b1   = '0;
    b2   = '0;
    b3   = '0;
    val  = '0;
    priority if (req_byte_0[7:4] != 4'd0) begin
      // Multi-frame requests are rejected for every service.
      emit = 1'b1;
      len  = LenShort;
      b1   = NegSid;
      b2   = req_byte_1;
      b3   = NrcFormat;
    end else if (req_byte_1 == SvcSession) begin
      priority if (session_open && (req_byte_2 == SubLeave)) begin
        session_open_next = 1'b0;
        emit = 1'b1;
        len  = LenShort;
        b1   = SvcSession + PosOffset;
        b3   = node_id;
      end else if (((req_byte_2 == SubOpen) && !functional) ||
                   ((req_byte_2 == SubOpenSer) && (value == serial_number))) begin
        session_open_next = 1'b1;
        emit = 1'b1;
        len  = LenWord;
        b1   = SvcSession + PosOffset;
        b3   = node_id;
        val  = serial_number;
      end else begin
        emit = 1'b0;
      end
    end else if (req_byte_1 == SvcRead) begin
      emit = 1'b1;
      if (pid_ok) begin
        len = LenWord;
        b1  = SvcRead + PosOffset;
        b3  = req_byte_3;
        unique case (pid_sel)
          PID_SERIAL: val = serial_number;
          PID_NODE: begin
            len = LenByte;
            val = {{(WordW-ByteW){1'b0}}, node_id};
          end
          PID_GAIN_P: val = gain_p_bits;
          PID_GAIN_I: val = gain_i_bits;
          PID_GAIN_D: val = gain_d_bits;
          PID_LIMIT:  val = drive_limit_bits;
          PID_BUS_ID: begin
            len = LenHalf;
            val = {{(WordW-BusIdW){1'b0}}, bus_id_param};
          end
          default: val = '0;
        endcase
      end else begin
        len = LenShort;
        b1  = NegSid;
        b2  = SvcRead;
        b3  = NrcSubfunc;
      end
    end else if (req_byte_1 == SvcWrite) begin
      if (session_open || !functional) begin
        emit = 1'b1;
        len  = LenShort;
        if (pid_ok) begin
          save = 1'b1;
          b1   = SvcWrite + PosOffset;
          b2   = req_byte_2;
          b3   = req_byte_3;
          unique case (pid_sel)
            PID_SERIAL: serial_number_next    = value;
            PID_NODE:   node_id_next          = req_byte_4;
            PID_GAIN_P: gain_p_bits_next      = value;
            PID_GAIN_I: gain_i_bits_next      = value;
            PID_GAIN_D: gain_d_bits_next      = value;
            PID_LIMIT:  drive_limit_bits_next = value;
            PID_BUS_ID: bus_id_param_next     = value[BusIdW-1:0];
            default:    save = 1'b0;
          endcase
        end else begin
          b1 = NegSid;
          b2 = SvcWrite;
          b3 = NrcSubfunc;
        end
      end
    end else if (!functional) begin
      // Unknown service on a physical request.
      emit = 1'b1;
      len  = LenShort;
      b1   = NegSid;
      b2   = req_byte_1;
      b3   = NrcService;
    end else begin
      emit = 1'b0;
    end
  end

  // State registers and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      session_open     <= 1'b0;
      serial_number    <= '0;
      node_id          <= '0;
      gain_p_bits      <= '0;
      gain_i_bits      <= '0;
      gain_d_bits      <= '0;
      drive_limit_bits <= '0;
      bus_id_param     <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        session_open     <= session_open_next;
        serial_number    <= serial_number_next;
        node_id          <= node_id_next;
        gain_p_bits      <= gain_p_bits_next;
        gain_i_bits      <= gain_i_bits_next;
        gain_d_bits      <= gain_d_bits_next;
        drive_limit_bits <= drive_limit_bits_next;
        bus_id_param     <= bus_id_param_next;
        result_valid     <= emit;
      end
    end
  end

  // Response payload; the identifier already reflects a node id written by this item.
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      resp_valid   <= 1'b1;
      resp_id      <= RespBase + {{(RespIdW-ByteW){1'b0}}, node_id_next};
      resp_byte_0  <= len;
      resp_byte_1  <= b1;
      resp_byte_2  <= b2;
      resp_byte_3  <= b3;
      resp_byte_4  <= val[7:0];
      resp_byte_5  <= val[15:8];
      resp_byte_6  <= val[23:16];
      resp_byte_7  <= val[31:24];
      save_request <= save;
    end
  end

endmodule

@@ test/tb_can_diagnostic_responder.sv @@
// Self-checking testbench for the CAN diagnostic responder with its own response predictor.
`timescale 1ns / 1ps

module tb_can_diagnostic_responder;
  import cdr_pkg::*;

  // One request item: identifier and the eight data bytes, byte 0 in the low bits.
  typedef struct packed {
    logic [FrameIdW-1:0] fid;
    logic [63:0]         data;
  } frame_t;

  // One expected response item.
  typedef struct packed {
    logic               save;
    logic [RespIdW-1:0] id;
    logic [63:0]        data;
  } resp_t;

  localparam logic [FrameIdW-1:0] PhysId = 11'h6A5;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                frame_valid = 1'b0;
  logic                frame_ready;
  logic [FrameIdW-1:0] frame_id = '0;
  logic [ByteW-1:0]    req_byte_0 = '0;
  logic [ByteW-1:0]    req_byte_1 = '0;
  logic [ByteW-1:0]    req_byte_2 = '0;
  logic [ByteW-1:0]    req_byte_3 = '0;
  logic [ByteW-1:0]    req_byte_4 = '0;
  logic [ByteW-1:0]    req_byte_5 = '0;
  logic [ByteW-1:0]    req_byte_6 = '0;
  logic [ByteW-1:0]    req_byte_7 = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic                resp_valid;
  logic [RespIdW-1:0]  resp_id;
  logic [ByteW-1:0]    resp_byte_0;
  logic [ByteW-1:0]    resp_byte_1;
  logic [ByteW-1:0]    resp_byte_2;
  logic [ByteW-1:0]    resp_byte_3;
  logic [ByteW-1:0]    resp_byte_4;
  logic [ByteW-1:0]    resp_byte_5;
  logic [ByteW-1:0]    resp_byte_6;
  logic [ByteW-1:0]    resp_byte_7;
  logic                save_request;

  // Predicted responder state.
  logic              sess_open_q;
  logic [WordW-1:0]  serial_q;
  logic [ByteW-1:0]  node_q;
  logic [WordW-1:0]  gain_p_q;
  logic [WordW-1:0]  gain_i_q;
  logic [WordW-1:0]  gain_d_q;
  logic [WordW-1:0]  limit_q;
  logic [BusIdW-1:0] bus_id_q;

  resp_t pending_resp[$];
  int    error_count = 0;
  int    req_idle_pct = 0;
  int    recv_idle_pct = 0;

  can_diagnostic_responder dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame_id     (frame_id),
    .req_byte_0   (req_byte_0),
    .req_byte_1   (req_byte_1),
    .req_byte_2   (req_byte_2),
    .req_byte_3   (req_byte_3),
    .req_byte_4   (req_byte_4),
    .req_byte_5   (req_byte_5),
    .req_byte_6   (req_byte_6),
    .req_byte_7   (req_byte_7),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .resp_valid   (resp_valid),
    .resp_id      (resp_id),
    .resp_byte_0  (resp_byte_0),
    .resp_byte_1  (resp_byte_1),
    .resp_byte_2  (resp_byte_2),
    .resp_byte_3  (resp_byte_3),
    .resp_byte_4  (resp_byte_4),
    .resp_byte_5  (resp_byte_5),
    .resp_byte_6  (resp_byte_6),
    .resp_byte_7  (resp_byte_7),
    .save_request (save_request)
  );

  always #2ns clk = ~clk;

  // Receiver stalls at random.
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Builds a request item from its parts; pid goes out high byte first.
  function automatic frame_t make_frame(logic [FrameIdW-1:0] fid, logic [ByteW-1:0] pci,
                                        logic [ByteW-1:0] sid, logic [PidW-1:0] pid,
                                        logic [WordW-1:0] value);
    make_frame.fid  = fid;
    make_frame.data = {value, pid[7:0], pid[15:8], sid, pci};
  endfunction

  // Forms a response under the current node id.
  function automatic resp_t positive_frame(logic [ByteW-1:0] len, logic [ByteW-1:0] b1,
                                           logic [ByteW-1:0] b2, logic [ByteW-1:0] b3,
                                           logic [WordW-1:0] value);
    positive_frame.save = 1'b0;
    positive_frame.id   = RespBase + RespIdW'(node_q);
    positive_frame.data = {value, b3, b2, b1, len};
  endfunction

  // Clears the predicted state as reset does.
  task automatic clear_state();
    sess_open_q = 1'b0;
    serial_q    = '0;
    node_q      = '0;
    gain_p_q    = '0;
    gain_i_q    = '0;
    gain_d_q    = '0;
    limit_q     = '0;
    bus_id_q    = '0;
  endtask

  // Works out the response of the responder to one request and updates its state.
  task automatic answer_request(input frame_t f, output bit answered, output resp_t rsp);
    logic [ByteW-1:0]  pci;
    logic [ByteW-1:0]  sid;
    logic [ByteW-1:0]  sub;
    logic [PidW-1:0]   pid;
    logic [WordW-1:0]  value;
    logic              functional;
    logic              known_pid;
    pid_t              param;
    pci        = f.data[7:0];
    sid        = f.data[15:8];
    sub        = f.data[23:16];
    pid        = {f.data[23:16], f.data[31:24]};
    value      = f.data[63:32];
    functional = (f.fid == FuncId);
    known_pid  = (pid[15:3] == '0) && (pid[2:0] != 3'd0);
    param      = pid_t'(pid[2:0]);
    answered   = 1'b0;
    rsp        = '0;

    if (pci[7:4] != 4'd0) begin
      // Multi-frame control byte is a format error for any service.
      answered = 1'b1;
      rsp = positive_frame(LenShort, NegSid, sid, NrcFormat, '0);
    end else if (sid == SvcSession) begin
      if (sess_open_q && sub == SubLeave) begin
        sess_open_q = 1'b0;
        answered = 1'b1;
        rsp = positive_frame(LenShort, SvcSession + PosOffset, '0, node_q, '0);
      end else if ((sub == SubOpen && !functional) ||
                   (sub == SubOpenSer && value == serial_q)) begin
        sess_open_q = 1'b1;
        answered = 1'b1;
        rsp = positive_frame(LenWord, SvcSession + PosOffset, '0, node_q, serial_q);
      end
    end else if (sid == SvcRead) begin
      answered = 1'b1;
      if (!known_pid) begin
        rsp = positive_frame(LenShort, NegSid, sid, NrcSubfunc, '0);
      end else begin
        case (param)
          PID_SERIAL: rsp = positive_frame(LenWord, SvcRead + PosOffset, '0, pid[7:0], serial_q);
          PID_NODE:   rsp = positive_frame(LenByte, SvcRead + PosOffset, '0, pid[7:0],
                                           WordW'(node_q));
          PID_GAIN_P: rsp = positive_frame(LenWord, SvcRead + PosOffset, '0, pid[7:0], gain_p_q);
          PID_GAIN_I: rsp = positive_frame(LenWord, SvcRead + PosOffset, '0, pid[7:0], gain_i_q);
          PID_GAIN_D: rsp = positive_frame(LenWord, SvcRead + PosOffset, '0, pid[7:0], gain_d_q);
          PID_LIMIT:  rsp = positive_frame(LenWord, SvcRead + PosOffset, '0, pid[7:0], limit_q);
          default:    rsp = positive_frame(LenHalf, SvcRead + PosOffset, '0, pid[7:0],
                                           WordW'(bus_id_q));
        endcase
      end
    end else if (sid == SvcWrite) begin
      // A functional write without a session is dropped silently.
      if (sess_open_q || !functional) begin
        answered = 1'b1;
        if (!known_pid) begin
          rsp = positive_frame(LenShort, NegSid, sid, NrcSubfunc, '0);
        end else begin
          case (param)
            PID_SERIAL: serial_q = value;
            PID_NODE:   node_q   = value[7:0];
            PID_GAIN_P: gain_p_q = value;
            PID_GAIN_I: gain_i_q = value;
            PID_GAIN_D: gain_d_q = value;
            PID_LIMIT:  limit_q  = value;
            default:    bus_id_q = value[15:0];
          endcase
          // The response already carries a freshly written node id.
          rsp = positive_frame(LenShort, SvcWrite + PosOffset, pid[15:8], pid[7:0], '0);
          rsp.save = 1'b1;
        end
      end
    end else if (!functional) begin
      answered = 1'b1;
      rsp = positive_frame(LenShort, NegSid, sid, NrcService, '0);
    end
  endtask

  // Offers one request item, with random idle cycles first, and predicts its response.
  // Valid stays high on return so back-to-back items need no second assignment.
  task automatic send_request(input frame_t f);
    bit    answered;
    resp_t rsp;
    while ($urandom_range(99) < req_idle_pct) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame_id    <= f.fid;
    req_byte_0  <= f.data[7:0];
    req_byte_1  <= f.data[15:8];
    req_byte_2  <= f.data[23:16];
    req_byte_3  <= f.data[31:24];
    req_byte_4  <= f.data[39:32];
    req_byte_5  <= f.data[47:40];
    req_byte_6  <= f.data[55:48];
    req_byte_7  <= f.data[63:56];
    do @(posedge clk); while (!frame_ready);
    answer_request(f, answered, rsp);
    if (answered) pending_resp.push_back(rsp);
  endtask

  // Stops sending and waits until every predicted response has come.
  task automatic wait_for_responses();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Draws a request: mostly well-formed services with random content, some noise.
  function automatic frame_t random_request();
    int               kind;
    logic [FrameIdW-1:0] fid;
    logic [ByteW-1:0] pci;
    logic [ByteW-1:0] sid;
    logic [PidW-1:0]  pid;
    logic [WordW-1:0] value;
    kind  = $urandom_range(99);
    fid   = ($urandom_range(99) < 30) ? FuncId : FrameIdW'($urandom);
    pci   = ByteW'($urandom_range(15));
    value = $urandom;
    pid   = PidW'($urandom_range(1, 7));
    if ($urandom_range(9) == 0) pid = PidW'($urandom);
    if (kind < 25) begin
      sid = SvcWrite;
    end else if (kind < 50) begin
      sid = SvcRead;
    end else if (kind < 68) begin
      sid = SvcSession;
      case ($urandom_range(4))
        0: pid[15:8] = SubLeave;
        1: pid[15:8] = SubOpen;
        2, 3: begin
          pid[15:8] = SubOpenSer;
          if ($urandom_range(9) < 7) value = serial_q;
        end
        default: pid[15:8] = ByteW'($urandom);
      endcase
    end else if (kind < 76) begin
      pci = {4'($urandom_range(1, 15)), 4'($urandom)};
      sid = ByteW'($urandom);
    end else if (kind < 84) begin
      sid = ByteW'($urandom);
    end else begin
      pci = ByteW'($urandom);
      sid = ByteW'($urandom);
      pid = PidW'($urandom);
    end
    random_request = make_frame(fid, pci, sid, pid, value);
  endfunction

  // Compares one response field and records a mismatch.
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $error("%s mismatch: expected %h, got %h", name, want, got);
    end
  endtask

  // Checks each accepted response item against the oldest prediction.
  always @(posedge clk) begin
    resp_t       want;
    logic [63:0] got;
    if (!rst && result_valid && result_ready) begin
      got = {resp_byte_7, resp_byte_6, resp_byte_5, resp_byte_4,
             resp_byte_3, resp_byte_2, resp_byte_1, resp_byte_0};
      if (pending_resp.size() == 0) begin
        error_count++;
        $error("response item with none expected: id %h bytes %h", resp_id, got);
      end else begin
        want = pending_resp.pop_front();
        compare_field("resp_valid", 32'd1, 32'(resp_valid));
        compare_field("resp_id", 32'(want.id), 32'(resp_id));
        for (int i = 0; i < 8; i++) begin
          compare_field($sformatf("resp_byte_%0d", i), 32'(want.data[8*i +: 8]),
                        32'(got[8*i +: 8]));
        end
        compare_field("save_request", 32'(want.save), 32'(save_request));
      end
    end
  end

  // Multi-frame control bytes give a format error whatever the service.
  task automatic test_format_error();
    send_request(make_frame(11'h7FF, 8'hF0, SvcWrite, 16'h0001, 32'h1234_5678));
    send_request(make_frame(FuncId, 8'h10, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
  endtask

  // Unknown services are refused on physical requests and ignored on functional ones.
  task automatic test_unknown_service();
    send_request(make_frame(11'h000, 8'h02, 8'h00, 16'h0000, 32'h0));
    send_request(make_frame(FuncId, 8'h02, 8'h3E, 16'h0000, 32'h0));
  endtask

  // Session control: leave, open, open by serial number, and ignored subfunctions.
  task automatic test_session_control();
    send_request(make_frame(PhysId, 8'h02, SvcSession, {SubLeave, 8'h00}, 32'h0));
    send_request(make_frame(FuncId, 8'h02, SvcSession, {SubOpen, 8'h00}, 32'h0));
    send_request(make_frame(PhysId, 8'h02, SvcSession, {SubOpen, 8'h00}, 32'h0));
    send_request(make_frame(FuncId, 8'h02, SvcSession, {SubLeave, 8'h00}, 32'h0));
    send_request(make_frame(FuncId, 8'h06, SvcSession, {SubOpenSer, 8'h00}, 32'h0000_0001));
    send_request(make_frame(FuncId, 8'h06, SvcSession, {SubOpenSer, 8'h00}, 32'h0));
    send_request(make_frame(PhysId, 8'h02, SvcSession, {8'hFF, 8'h00}, 32'h0));
    send_request(make_frame(PhysId, 8'h02, SvcSession, {SubLeave, 8'hFF}, 32'h0));
  endtask

  // Writes every parameter with all ones, including the node id used in the reply.
  task automatic test_parameter_write();
    send_request(make_frame(FuncId, 8'h07, SvcWrite, 16'h0003, 32'hDEAD_BEEF));
    for (int p = 1; p <= 7; p++) begin
      send_request(make_frame(PhysId, 8'h07, SvcWrite, PidW'(p), 32'hFFFF_FFFF));
    end
    send_request(make_frame(PhysId, 8'h07, SvcWrite, 16'h0100, 32'h0));
  endtask

  // Reads every parameter back and two unsupported identifiers.
  task automatic test_parameter_read();
    for (int p = 1; p <= 7; p++) begin
      send_request(make_frame(FuncId, 8'h03, SvcRead, PidW'(p), 32'h0));
    end
    send_request(make_frame(PhysId, 8'h03, SvcRead, 16'h0000, 32'h0));
    send_request(make_frame(PhysId, 8'h03, SvcRead, 16'hFFFF, 32'h0));
  endtask

  // Random traffic under one idling pattern, drained at the end.
  task automatic test_random_traffic(input int count, input int req_pct, input int recv_pct);
    req_idle_pct  = req_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      send_request(random_request());
    end
    wait_for_responses();
  endtask

  initial begin
    clear_state();
    req_idle_pct  = 17;
    recv_idle_pct = 59;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_format_error();
    test_unknown_service();
    test_session_control();
    test_parameter_write();
    test_parameter_read();
    wait_for_responses();

    test_random_traffic(500, 17, 59);
    test_random_traffic(500, 59, 17);
    test_random_traffic(500, 0, 0);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
